/* hdl/dote_pkg.sv */
// dote_pkg: widths, codes and fixed constants of the operation time evaluator
// used by dote_isqrt and drone_operation_time_eval; depends on nothing else

package dote_pkg;

   // field widths
   localparam int COORD_W    = 24;
   localparam int SCALE_W    = 32;
   localparam int ACC_W      = 40;
   localparam int TIME_W     = 48;
   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = TIME_W;

   // leg arithmetic: |d| needs one bit more than a coordinate
   localparam int MAG_W  = COORD_W + 1;
   localparam int ROOT_W = MAG_W;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int HI_W   = ACC_W - MUL_W;
   localparam int HIP_W  = HI_W + SCALE_W;

   // fixed-point scaling of length * scale down to Q.8
   localparam int COORD_FRAC_BITS = 8;
   localparam int TIME_SHIFT      = COORD_FRAC_BITS + 8;
   localparam int HI_SAT_SHIFT    = TIME_SHIFT + 16;
   localparam int HI_LEFT_SHIFT   = MUL_W - TIME_SHIFT;
   localparam int SUM_W           = TIME_W + 2;

   localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
   localparam logic [ACC_W-1:0]   ACC_MAX     = '1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_TRUCK_SCALE = 1'b0,
      CSR_DRONE_SCALE = 1'b1
   } csr_index_type;

   // which leg is being measured
   typedef enum logic [1:0] {
      LEG_TO_CUST  = 2'd0,
      LEG_TO_RETR  = 2'd1,
      LEG_TRUCK    = 2'd2
   } leg_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_ACCUM,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_SCALE,
      ST_TOTAL,
      ST_RESULT
   } state_type;

endpackage

/* hdl/dote_isqrt.sv */
// dote_isqrt: iterative integer square root, one root bit per cycle
// depends on dote_pkg for its widths

module dote_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dote_pkg::SQ_W-1:0]   radicand,
   output logic                        done,
   output logic [dote_pkg::ROOT_W-1:0] root
);

   localparam int CNT_W = $clog2(dote_pkg::ROOT_W);
   localparam int TRY_W = dote_pkg::REM_W + 2;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [dote_pkg::SQ_W-1:0]   rad_ff, rad_in;
   logic [dote_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [dote_pkg::ROOT_W-1:0] root_ff, root_in;

   logic [TRY_W-1:0] rem_sh;
   logic [TRY_W-1:0] trial;
   logic [TRY_W-1:0] rem_sub;
   logic             fits;

   // one restoring step: bring down two radicand bits, try root*4+1
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[dote_pkg::SQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      fits    = (rem_sh >= trial);
   end

   // step control and datapath next values
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(dote_pkg::ROOT_W - 1);
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[dote_pkg::REM_W-1:0] : rem_sh[dote_pkg::REM_W-1:0];
         root_in = {root_ff[dote_pkg::ROOT_W-2:0], fits};
         rad_in  = rad_ff << 2;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

/* hdl/drone_operation_time_eval.sv */
// drone_operation_time_eval: costs one truck-and-drone operation per run of customers
// depends on dote_pkg and dote_isqrt
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | req_tdata coords, req_tuser first, req_tlast
//  rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata op_time, rsp_tuser saturated
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// an item that is not the last customer measures only the leg to it, then returns to idle
// the last customer measures three legs, scales drone and truck length, offers the result
// each leg waits on the square root unit: 25 steps of one bit, then its done strobe
// the block takes one item at a time: req_tready is high only when idle
// a result is held on rsp until taken; rsp_tready low just holds it there
// reset is synchronous: scales return to 1.0, previous point and drone length to zero

module drone_operation_time_eval (
   input  logic                            clock,
   input  logic                            reset,
   // launch_x, launch_y, retrieve_x, retrieve_y, cust_x, cust_y
   input  logic [dote_pkg::REQ_DATA_W-1:0] req_tdata,
   // first_cust
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // op_time
   output logic [dote_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // time_saturated
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [dote_pkg::SCALE_W-1:0]    csr_wdata
);

   localparam int CW = dote_pkg::COORD_W;

   dote_pkg::state_type state_ff, state_in;
   dote_pkg::leg_type   leg_ff, leg_in;

   logic [dote_pkg::SCALE_W-1:0] truck_scale_ff, drone_scale_ff;

   logic [CW-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CW-1:0] from_x_ff, from_x_in, from_y_ff, from_y_in;
   logic [CW-1:0] launch_x_ff, launch_x_in, launch_y_ff, launch_y_in;
   logic [CW-1:0] retr_x_ff, retr_x_in, retr_y_ff, retr_y_in;
   logic [CW-1:0] cust_x_ff, cust_x_in, cust_y_ff, cust_y_in;
   logic          last_ff, last_in;

   logic [dote_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [dote_pkg::MAG_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [dote_pkg::SQ_W-1:0]   sumsq_ff, sumsq_in;
   logic [dote_pkg::PROD_W-1:0] prod_ff;
   logic [dote_pkg::HIP_W-1:0]  hi_ff, hi_in;
   logic [dote_pkg::TIME_W-1:0] term_ff, term_in;
   logic [dote_pkg::TIME_W-1:0] total_ff, total_in;
   logic                        sat_ff, sat_in;
   logic                        sel_truck_ff, sel_truck_in;

   logic                        accept;
   logic                        root_start;
   logic                        root_done;
   logic [dote_pkg::ROOT_W-1:0] root;
   logic [dote_pkg::SQ_W-1:0]   radicand;

   logic [CW-1:0]               pa_x, pa_y, pb_x, pb_y;
   logic [dote_pkg::MAG_W-1:0]  diff_x, diff_y;
   logic [dote_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [dote_pkg::ACC_W-1:0]  len;
   logic [dote_pkg::ACC_W:0]    acc_sum;
   logic                        hi_sat;
   logic [dote_pkg::SUM_W-1:0]  scaled;
   logic [dote_pkg::TIME_W:0]   total_sum;

   assign accept = req_tvalid & req_tready;

   // shared square root unit
   dote_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dote_pkg::ST_IDLE:      if (req_tvalid) state_in = dote_pkg::ST_DIFF;
         dote_pkg::ST_DIFF:      state_in = dote_pkg::ST_SQ_X;
         dote_pkg::ST_SQ_X:      state_in = dote_pkg::ST_SQ_Y;
         dote_pkg::ST_SQ_Y:      state_in = dote_pkg::ST_ROOT_GO;
         dote_pkg::ST_ROOT_GO:   state_in = dote_pkg::ST_ROOT_WAIT;
         dote_pkg::ST_ROOT_WAIT: if (root_done) state_in = dote_pkg::ST_ACCUM;
         dote_pkg::ST_ACCUM: begin
            if (leg_ff == dote_pkg::LEG_TRUCK) begin
               state_in = dote_pkg::ST_MUL_HI;
            end else if (leg_ff == dote_pkg::LEG_TO_CUST && !last_ff) begin
               state_in = dote_pkg::ST_IDLE;
            end else begin
               state_in = dote_pkg::ST_DIFF;
            end
         end
         dote_pkg::ST_MUL_HI:    state_in = dote_pkg::ST_MUL_LO;
         dote_pkg::ST_MUL_LO:    state_in = dote_pkg::ST_SCALE;
         dote_pkg::ST_SCALE:     state_in = dote_pkg::ST_TOTAL;
         dote_pkg::ST_TOTAL:     state_in = sel_truck_ff ? dote_pkg::ST_RESULT
                                                         : dote_pkg::ST_MUL_HI;
         dote_pkg::ST_RESULT:    if (rsp_tready) state_in = dote_pkg::ST_IDLE;
         default:                state_in = dote_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      root_start = 1'b0;
      unique case (state_ff)
         dote_pkg::ST_IDLE:    req_tready = 1'b1;
         dote_pkg::ST_ROOT_GO: root_start = 1'b1;
         dote_pkg::ST_RESULT:  rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // end points of the leg in hand
   always_comb begin
      unique case (leg_ff)
         dote_pkg::LEG_TO_CUST: begin
            pa_x = from_x_ff;   pa_y = from_y_ff;
            pb_x = cust_x_ff;   pb_y = cust_y_ff;
         end
         dote_pkg::LEG_TO_RETR: begin
            pa_x = cust_x_ff;   pa_y = cust_y_ff;
            pb_x = retr_x_ff;   pb_y = retr_y_ff;
         end
         dote_pkg::LEG_TRUCK: begin
            pa_x = launch_x_ff; pa_y = launch_y_ff;
            pb_x = retr_x_ff;   pb_y = retr_y_ff;
         end
         default: begin
            pa_x = '0; pa_y = '0;
            pb_x = '0; pb_y = '0;
         end
      endcase
      diff_x = {pa_x[CW-1], pa_x} - {pb_x[CW-1], pb_x};
      diff_y = {pa_y[CW-1], pa_y} - {pb_y[CW-1], pb_y};
   end

   // shared multiplier operands: squares, then length times scale in two halves
   always_comb begin
      len   = sel_truck_ff ? dote_pkg::ACC_W'(root) : acc_ff;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         dote_pkg::ST_SQ_X: begin
            mul_a = dote_pkg::MUL_W'(dx_ff);
            mul_b = dote_pkg::MUL_W'(dx_ff);
         end
         dote_pkg::ST_SQ_Y: begin
            mul_a = dote_pkg::MUL_W'(dy_ff);
            mul_b = dote_pkg::MUL_W'(dy_ff);
         end
         dote_pkg::ST_MUL_HI: begin
            mul_a = dote_pkg::MUL_W'(len[dote_pkg::ACC_W-1:dote_pkg::MUL_W]);
            mul_b = sel_truck_ff ? truck_scale_ff : drone_scale_ff;
         end
         dote_pkg::ST_MUL_LO: begin
            mul_a = len[dote_pkg::MUL_W-1:0];
            mul_b = sel_truck_ff ? truck_scale_ff : drone_scale_ff;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // radicand, running sums and scaling terms
   always_comb begin
      radicand  = sumsq_ff + prod_ff[dote_pkg::SQ_W-1:0];
      acc_sum   = {1'b0, acc_ff} + (dote_pkg::ACC_W + 1)'(root);
      hi_sat    = (hi_ff >> dote_pkg::HI_SAT_SHIFT) != '0;
      scaled    = (dote_pkg::SUM_W'(hi_ff) << dote_pkg::HI_LEFT_SHIFT)
                + dote_pkg::SUM_W'(prod_ff >> dote_pkg::TIME_SHIFT);
      total_sum = {1'b0, total_ff} + {1'b0, term_ff};
   end

   // datapath next values
   always_comb begin
      prev_x_in    = prev_x_ff;    prev_y_in   = prev_y_ff;
      from_x_in    = from_x_ff;    from_y_in   = from_y_ff;
      launch_x_in  = launch_x_ff;  launch_y_in = launch_y_ff;
      retr_x_in    = retr_x_ff;    retr_y_in   = retr_y_ff;
      cust_x_in    = cust_x_ff;    cust_y_in   = cust_y_ff;
      last_in      = last_ff;
      leg_in       = leg_ff;
      acc_in       = acc_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sumsq_in     = sumsq_ff;
      hi_in        = hi_ff;
      term_in      = term_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      sel_truck_in = sel_truck_ff;
      unique case (state_ff)
         // take the item; the first customer starts from the launch point
         dote_pkg::ST_IDLE: begin
            if (accept) begin
               launch_x_in = req_tdata[0*CW +: CW];
               launch_y_in = req_tdata[1*CW +: CW];
               retr_x_in   = req_tdata[2*CW +: CW];
               retr_y_in   = req_tdata[3*CW +: CW];
               cust_x_in   = req_tdata[4*CW +: CW];
               cust_y_in   = req_tdata[5*CW +: CW];
               last_in     = req_tlast;
               from_x_in   = req_tuser ? req_tdata[0*CW +: CW] : prev_x_ff;
               from_y_in   = req_tuser ? req_tdata[1*CW +: CW] : prev_y_ff;
               prev_x_in   = req_tdata[4*CW +: CW];
               prev_y_in   = req_tdata[5*CW +: CW];
               if (req_tuser) acc_in = '0;
               leg_in      = dote_pkg::LEG_TO_CUST;
            end
         end
         // absolute differences
         dote_pkg::ST_DIFF: begin
            dx_in = diff_x[dote_pkg::MAG_W-1] ? dote_pkg::MAG_W'(-diff_x) : diff_x;
            dy_in = diff_y[dote_pkg::MAG_W-1] ? dote_pkg::MAG_W'(-diff_y) : diff_y;
         end
         dote_pkg::ST_SQ_Y: begin
            sumsq_in = prod_ff[dote_pkg::SQ_W-1:0];
         end
         // fold a drone leg length in and pick the next leg; after the truck leg clear the total
         dote_pkg::ST_ACCUM: begin
            unique case (leg_ff)
               dote_pkg::LEG_TO_CUST: begin
                  acc_in = acc_sum[dote_pkg::ACC_W] ? dote_pkg::ACC_MAX
                                                    : acc_sum[dote_pkg::ACC_W-1:0];
                  leg_in = dote_pkg::LEG_TO_RETR;
               end
               dote_pkg::LEG_TO_RETR: begin
                  acc_in = acc_sum[dote_pkg::ACC_W] ? dote_pkg::ACC_MAX
                                                    : acc_sum[dote_pkg::ACC_W-1:0];
                  leg_in = dote_pkg::LEG_TRUCK;
               end
               dote_pkg::LEG_TRUCK: begin
                  total_in     = '0;
                  sat_in       = 1'b0;
                  sel_truck_in = 1'b0;
               end
               default: begin
                  leg_in = dote_pkg::LEG_TO_CUST;
               end
            endcase
         end
         dote_pkg::ST_MUL_LO: begin
            hi_in = prod_ff[dote_pkg::HIP_W-1:0];
         end
         // truncate to Q.8 and clip one time term
         dote_pkg::ST_SCALE: begin
            if (hi_sat || scaled > dote_pkg::SUM_W'(dote_pkg::TIME_MAX)) begin
               term_in = dote_pkg::TIME_MAX;
               sat_in  = 1'b1;
            end else begin
               term_in = scaled[dote_pkg::TIME_W-1:0];
            end
         end
         // add the term, clip the total
         dote_pkg::ST_TOTAL: begin
            if (total_sum[dote_pkg::TIME_W]) begin
               total_in = dote_pkg::TIME_MAX;
               sat_in   = 1'b1;
            end else begin
               total_in = total_sum[dote_pkg::TIME_W-1:0];
            end
            sel_truck_in = 1'b1;
            if (sel_truck_ff) acc_in = '0;
         end
         default: begin
            last_in = last_ff;
         end
      endcase
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dote_pkg::ST_IDLE;
         leg_ff         <= dote_pkg::LEG_TO_CUST;
         truck_scale_ff <= dote_pkg::SCALE_RESET;
         drone_scale_ff <= dote_pkg::SCALE_RESET;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         acc_ff         <= '0;
         sel_truck_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         leg_ff       <= leg_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         acc_ff       <= acc_in;
         sel_truck_ff <= sel_truck_in;
         if (csr_we) begin
            unique case (csr_index)
               dote_pkg::CSR_TRUCK_SCALE: truck_scale_ff <= csr_wdata;
               dote_pkg::CSR_DRONE_SCALE: drone_scale_ff <= csr_wdata;
               default:                   truck_scale_ff <= truck_scale_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      from_x_ff   <= from_x_in;
      from_y_ff   <= from_y_in;
      launch_x_ff <= launch_x_in;
      launch_y_ff <= launch_y_in;
      retr_x_ff   <= retr_x_in;
      retr_y_ff   <= retr_y_in;
      cust_x_ff   <= cust_x_in;
      cust_y_ff   <= cust_y_in;
      last_ff     <= last_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sumsq_ff    <= sumsq_in;
      prod_ff     <= mul_a * mul_b;
      hi_ff       <= hi_in;
      term_ff     <= term_in;
      total_ff    <= total_in;
      sat_ff      <= sat_in;
   end

   assign rsp_tdata = total_ff;
   assign rsp_tuser = sat_ff;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for drone_operation_time_eval, one operation cost per last customer
// needs dote_pkg and the block's rtl; carries its own model of the leg sums and the scaling
`timescale 1ns / 100ps

module tb_top;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 150;
   localparam int MAX_WAIT     = 17;

   // one customer item, launch_x in the lowest bits as on req_tdata
   typedef struct packed {
      logic [dote_pkg::COORD_W-1:0] cust_y;
      logic [dote_pkg::COORD_W-1:0] cust_x;
      logic [dote_pkg::COORD_W-1:0] retr_y;
      logic [dote_pkg::COORD_W-1:0] retr_x;
      logic [dote_pkg::COORD_W-1:0] launch_y;
      logic [dote_pkg::COORD_W-1:0] launch_x;
   } coords_type;

   typedef struct packed {
      logic [dote_pkg::TIME_W-1:0] op_time;
      logic                        saturated;
   } cost_type;

   typedef struct packed {
      logic       known;
      cost_type   want;
      logic       last;
      logic       first;
      coords_type pt;
   } stop_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [dote_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            req_tlast  = 1'b0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dote_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_we     = 1'b0;
   dote_pkg::csr_index_type         csr_index  = dote_pkg::CSR_TRUCK_SCALE;
   logic [dote_pkg::SCALE_W-1:0]    csr_wdata  = '0;

   // model state
   logic [dote_pkg::SCALE_W-1:0] truck_scale_q = dote_pkg::SCALE_RESET;
   logic [dote_pkg::SCALE_W-1:0] drone_scale_q = dote_pkg::SCALE_RESET;
   logic [dote_pkg::COORD_W-1:0] last_x = '0;
   logic [dote_pkg::COORD_W-1:0] last_y = '0;
   logic [dote_pkg::ACC_W-1:0]   path_len = '0;

   cost_type cost_due[$];
   stop_type route_table[$];
   int       mismatches  = 0;
   int       idle_cycles = 0;
   logic     calm = 1'b0;

   drone_operation_time_eval dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bit-serial integer square root, floor
   function automatic logic [dote_pkg::ROOT_W-1:0] int_sqrt(input logic [63:0] v);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = v;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[dote_pkg::ROOT_W-1:0];
   endfunction

   // euclidean distance between two signed points
   function automatic logic [dote_pkg::ROOT_W-1:0] leg_len(
         input logic [dote_pkg::COORD_W-1:0] ax, ay, bx, by);
      logic [dote_pkg::MAG_W-1:0] dx;
      logic [dote_pkg::MAG_W-1:0] dy;
      logic [63:0]                sq;
      dx = {ax[dote_pkg::COORD_W-1], ax} - {bx[dote_pkg::COORD_W-1], bx};
      dy = {ay[dote_pkg::COORD_W-1], ay} - {by[dote_pkg::COORD_W-1], by};
      if (dx[dote_pkg::MAG_W-1]) dx = -dx;
      if (dy[dote_pkg::MAG_W-1]) dy = -dy;
      sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
      return int_sqrt(sq);
   endfunction

   function automatic logic [dote_pkg::ACC_W-1:0] add_clip(
         input logic [dote_pkg::ACC_W-1:0] a,
         input logic [dote_pkg::ROOT_W-1:0] b);
      logic [dote_pkg::ACC_W:0] s;
      s = {1'b0, a} + (dote_pkg::ACC_W + 1)'(b);
      return s[dote_pkg::ACC_W] ? dote_pkg::ACC_MAX : s[dote_pkg::ACC_W-1:0];
   endfunction

   // length times q16.16 scale, floored to q.8; top bit flags clipping
   function automatic logic [dote_pkg::TIME_W:0] scale_time(
         input logic [dote_pkg::ACC_W-1:0] len,
         input logic [dote_pkg::SCALE_W-1:0] sc);
      logic [71:0] prod;
      prod = (72'(len) * 72'(sc)) >> dote_pkg::TIME_SHIFT;
      if (prod > 72'(dote_pkg::TIME_MAX)) return {1'b1, dote_pkg::TIME_MAX};
      return {1'b0, prod[dote_pkg::TIME_W-1:0]};
   endfunction

   // advance the path by one customer; on the last one cost the operation
   function automatic void cost_stop(input stop_type s, output logic due,
                                     output cost_type res);
      logic [dote_pkg::COORD_W-1:0] fx;
      logic [dote_pkg::COORD_W-1:0] fy;
      logic [dote_pkg::ACC_W-1:0]   drone_len;
      logic [dote_pkg::TIME_W:0]    t_drone;
      logic [dote_pkg::TIME_W:0]    t_truck;
      logic [dote_pkg::TIME_W:0]    total;
      if (s.first) begin
         path_len = '0;
         fx = s.pt.launch_x;
         fy = s.pt.launch_y;
      end else begin
         fx = last_x;
         fy = last_y;
      end
      path_len = add_clip(path_len, leg_len(fx, fy, s.pt.cust_x, s.pt.cust_y));
      last_x = s.pt.cust_x;
      last_y = s.pt.cust_y;
      due = s.last;
      res = '0;
      if (s.last) begin
         drone_len = add_clip(path_len, leg_len(s.pt.cust_x, s.pt.cust_y,
                                                s.pt.retr_x, s.pt.retr_y));
         t_drone = scale_time(drone_len, drone_scale_q);
         t_truck = scale_time(dote_pkg::ACC_W'(leg_len(s.pt.launch_x, s.pt.launch_y,
                                                       s.pt.retr_x, s.pt.retr_y)),
                              truck_scale_q);
         total = (dote_pkg::TIME_W + 1)'(t_drone[dote_pkg::TIME_W-1:0])
               + (dote_pkg::TIME_W + 1)'(t_truck[dote_pkg::TIME_W-1:0]);
         res.saturated = t_drone[dote_pkg::TIME_W] | t_truck[dote_pkg::TIME_W]
                       | total[dote_pkg::TIME_W];
         res.op_time   = total[dote_pkg::TIME_W] ? dote_pkg::TIME_MAX
                                                 : total[dote_pkg::TIME_W-1:0];
         path_len = '0;
      end
   endfunction

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // mix of full range, near origin and corner values
   function automatic logic [dote_pkg::COORD_W-1:0] rand_coord();
      logic [dote_pkg::COORD_W-1:0] c;
      case ($urandom_range(0, 3))
         0: c = dote_pkg::COORD_W'(int'($urandom_range(0, 4095)) - 2048);
         1: begin
            case ($urandom_range(0, 3))
               0: c = 24'h800000;
               1: c = 24'h7fffff;
               2: c = '0;
               default: c = '1;
            endcase
         end
         default: c = dote_pkg::COORD_W'($urandom);
      endcase
      return c;
   endfunction

   // present one item, predict once it is taken; returns at a falling edge
   task automatic send_stop(input stop_type s);
      int       gap;
      logic     due;
      cost_type got;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = s.pt;
      req_tuser  = s.first;
      req_tlast  = s.last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      cost_stop(s, due, got);
      if (due) cost_due = {cost_due, (s.known ? s.want : got)};
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_tvalid = 1'b0;
      while (cost_due.size() != 0) @(negedge clock);
   endtask

   // registers change only with the block at rest
   task automatic write_scale(input dote_pkg::csr_index_type idx,
                              input logic [dote_pkg::SCALE_W-1:0] v);
      wait_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == dote_pkg::CSR_TRUCK_SCALE) truck_scale_q = v;
      else drone_scale_q = v;
   endtask

   task automatic add_row(input logic [dote_pkg::COORD_W-1:0] lx, ly, rx, ry, cx, cy,
                          input logic first, last, known,
                          input logic [dote_pkg::TIME_W-1:0] t);
      stop_type s;
      s = '0;
      s.pt.launch_x = lx;
      s.pt.launch_y = ly;
      s.pt.retr_x   = rx;
      s.pt.retr_y   = ry;
      s.pt.cust_x   = cx;
      s.pt.cust_y   = cy;
      s.first = first;
      s.last  = last;
      s.known = known;
      s.want  = '{op_time: t, saturated: 1'b0};
      route_table = {route_table, s};
   endtask

   // random operations, mostly well formed, some with broken first/last marks
   task automatic run_ops(input int n_items);
      int   sent;
      int   n_cust;
      int   style;
      logic [dote_pkg::COORD_W-1:0] lx, ly, rx, ry;
      stop_type s;
      sent = 0;
      while (sent < n_items) begin
         style  = $urandom_range(0, 9);
         n_cust = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
         lx = rand_coord();
         ly = rand_coord();
         rx = rand_coord();
         ry = rand_coord();
         for (int i = 0; i < n_cust; i++) begin
            s = '0;
            s.pt.launch_x = lx;
            s.pt.launch_y = ly;
            s.pt.retr_x   = rx;
            s.pt.retr_y   = ry;
            s.pt.cust_x   = rand_coord();
            s.pt.cust_y   = rand_coord();
            if (style < 8) begin
               s.first = (i == 0);
               s.last  = (i == n_cust - 1);
            end else begin
               s.first = 1'($urandom_range(0, 1));
               s.last  = 1'($urandom_range(0, 1));
               if (style == 9) begin
                  s.pt.launch_x = rand_coord();
                  s.pt.retr_y   = rand_coord();
               end
            end
            send_stop(s);
            sent++;
         end
      end
   endtask

   // long zigzag between opposite corners, enough to clip the time
   task automatic send_chain(input int n_cust);
      stop_type s;
      for (int i = 0; i < n_cust; i++) begin
         s = '0;
         s.pt.launch_x = 24'h800000;
         s.pt.launch_y = 24'h800000;
         s.pt.retr_x   = 24'h7fffff;
         s.pt.retr_y   = 24'h7fffff;
         s.pt.cust_x   = (i % 2 == 0) ? 24'h7fffff : 24'h800000;
         s.pt.cust_y   = (i % 2 == 0) ? 24'h7fffff : 24'h800000;
         s.first = (i == 0);
         s.last  = (i == n_cust - 1);
         send_stop(s);
      end
   endtask

   // result side: random back-pressure, compare against the oldest prediction
   initial begin
      cost_type want;
      int       stall;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (cost_due.size() == 0) begin
            $display("%0t: unexpected result, op_time %h saturated %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = cost_due.pop_front();
            if (rsp_tdata !== want.op_time) begin
               $display("%0t: op_time expected %h got %h", $time, want.op_time, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== want.saturated) begin
               $display("%0t: saturated expected %b got %b", $time, want.saturated, rsp_tuser);
               mismatches++;
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed items at scale 1.0, so op_time is the raw length sum
      // missing first straight after reset starts at the origin
      add_row(24'h600, 24'h800, 24'h600, 24'h800, 24'h300, 24'h400, 1'b0, 1'b1, 1'b1, 48'd2560);
      add_row('0, '0, '0, '0, '0, '0, 1'b1, 1'b1, 1'b1, 48'd0);
      // single customer, 3-4-5 out and back
      add_row('0, '0, '0, '0, 24'h300, 24'h400, 1'b1, 1'b1, 1'b1, 48'd2560);
      add_row('1, '1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, 48'd0);
      add_row(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              1'b1, 1'b1, 1'b1, 48'd0);
      add_row(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
              1'b1, 1'b1, 1'b1, 48'd0);
      // drone idle at launch, only the truck leg and the hop to retrieval
      add_row('0, '0, 24'h300, 24'h400, '0, '0, 1'b1, 1'b1, 1'b1, 48'd2560);
      // corner to corner legs
      add_row(24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff,
              1'b1, 1'b1, 1'b0, '0);
      add_row(24'h7fffff, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 24'h7fffff,
              1'b1, 1'b1, 1'b0, '0);
      // three customer operation
      add_row(24'h1000, -24'sd8192, 24'h4000, 24'h2000, 24'h1800, 24'h0100,
              1'b1, 1'b0, 1'b0, '0);
      add_row(24'h1000, -24'sd8192, 24'h4000, 24'h2000, -24'sd300, 24'h3000,
              1'b0, 1'b0, 1'b0, '0);
      add_row(24'h1000, -24'sd8192, 24'h4000, 24'h2000, 24'h0055, -24'sd77,
              1'b0, 1'b1, 1'b0, '0);
      // repeated first drops the open operation
      add_row(24'h0200, 24'h0200, 24'h0900, 24'h0100, 24'h7fffff, 24'h800000,
              1'b1, 1'b0, 1'b0, '0);
      add_row(24'h0300, 24'h0100, 24'h0900, 24'h0100, 24'h0500, 24'h0500,
              1'b1, 1'b1, 1'b0, '0);
      // missing first after a finished operation, from the last customer
      add_row(24'h0300, 24'h0100, -24'sd2560, 24'h0a00, 24'h0123, 24'h0456,
              1'b0, 1'b1, 1'b0, '0);
      add_row('0, '0, 24'h0400, 24'h0400, 24'h0f00, -24'sd3840, 1'b0, 1'b0, 1'b0, '0);
      add_row('0, '0, 24'h0400, 24'h0400, 24'h0010, 24'h0020, 1'b0, 1'b1, 1'b0, '0);
      // alternating bit patterns
      add_row(24'haaaaaa, 24'h555555, 24'h555555, 24'haaaaaa, 24'haaaaaa, 24'haaaaaa,
              1'b1, 1'b1, 1'b0, '0);
      add_row(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 24'h555555, 24'h555555,
              1'b1, 1'b1, 1'b0, '0);
      // open operation left behind for the first random phase
      add_row(24'h0100, 24'h0100, 24'h0200, 24'h0200, 24'h0300, 24'h0300, 1'b1, 1'b0, 1'b0, '0);
      for (int i = 0; i < route_table.size(); i++) send_stop(route_table[i]);

      // zero scales: every time collapses to zero
      write_scale(dote_pkg::CSR_TRUCK_SCALE, '0);
      write_scale(dote_pkg::CSR_DRONE_SCALE, '0);
      run_ops(40);

      // largest scales, no idling, long path that clips
      write_scale(dote_pkg::CSR_TRUCK_SCALE, '1);
      write_scale(dote_pkg::CSR_DRONE_SCALE, '1);
      calm = 1'b1;
      send_chain(190);
      run_ops(30);
      calm = 1'b0;

      // random scales, with a pause for every result half way
      write_scale(dote_pkg::CSR_TRUCK_SCALE, $urandom);
      write_scale(dote_pkg::CSR_DRONE_SCALE, $urandom);
      run_ops(30);
      wait_results();
      run_ops(30);

      write_scale(dote_pkg::CSR_TRUCK_SCALE, '0);
      write_scale(dote_pkg::CSR_DRONE_SCALE, '1);
      run_ops(40);

      write_scale(dote_pkg::CSR_TRUCK_SCALE, $urandom_range(0, 32'h0010_0000));
      write_scale(dote_pkg::CSR_DRONE_SCALE, dote_pkg::SCALE_RESET);
      run_ops(40);

      wait_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && cost_due.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/dote_pkg.sv
hdl/dote_isqrt.sv
hdl/drone_operation_time_eval.sv
tb/tb_top.sv
